// ----- rtl/aabb_pkg.sv -----
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the box store and its query engine.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int COORD_W     = 16;
	localparam int MAX_VOLUMES = 64;
	localparam int IDX_W       = $clog2(MAX_VOLUMES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int BOX_W       = 4 * COORD_W;
	localparam int FRAC_W      = 16;
	localparam int T_W         = 32;
	localparam int TE_W        = 42;
	localparam int NUM_W       = COORD_W + FRAC_W;
	localparam int STEP_W      = $clog2(NUM_W);

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_ADD   = 3'd1,
		OP_POINT = 3'd2,
		OP_BOX   = 3'd3,
		OP_RAY   = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_RAY,
		ST_DONE
	} state_t;

	// Slab quotient selector: x min edge, x max edge, y min edge, y max edge.
	typedef enum logic [1:0] {
		SL_X0 = 2'd0,
		SL_X1 = 2'd1,
		SL_Y0 = 2'd2,
		SL_Y1 = 2'd3
	} slab_t;

	typedef struct packed {
		logic  load_query;
		logic  clear_count;
		logic  add_box;
		logic  set_full;
		logic  idx_clr;
		logic  idx_inc;
		logic  rd_en;
		logic  eval_box;
		logic  div_start;
		slab_t div_sel;
		logic  ray_eval;
		logic  out_load;
	} cmd_t;

	typedef struct packed {
		op_t              op;
		logic             count_zero;
		logic             store_at_max;
		logic             last;
		logic             div_done;
		logic             out_busy;
		logic [CNT_W-1:0] count;
	} status_t;

endpackage

// ----- rtl/aabb_ram.sv -----
// ----------------------------------------------------------------------------
// aabb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module aabb_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/aabb_div.sv -----
// ----------------------------------------------------------------------------
// aabb_div
// Radix-2 restoring divider for slab quotients: (num << 16) / den, one bit per
// cycle, with sign applied and the result saturated to signed Q16.16.
// ----------------------------------------------------------------------------
module aabb_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [aabb_pkg::COORD_W-1:0] num,
	input  logic [aabb_pkg::COORD_W-1:0] den,
	input  logic                        neg,
	output logic                        done,
	output logic signed [aabb_pkg::T_W-1:0] quo
);
	import aabb_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [NUM_W-1:0]  acc_q;
	logic [COORD_W-1:0] rem_q;
	logic [COORD_W-1:0] den_q;
	logic              neg_q;
	logic [COORD_W:0]  trial;
	logic              ge;
	logic [COORD_W:0]  diff;
	logic [NUM_W:0]    mag;

	assign trial = {rem_q, acc_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {num, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
			acc_q <= {acc_q[NUM_W-2:0], ge};
		end
	end

	// Saturate the magnitude to the signed Q16.16 range.
	assign mag = {1'b0, acc_q};
	always_comb begin
		if (!neg_q) begin
			if (acc_q[NUM_W-1]) quo = {1'b0, {(T_W-1){1'b1}}};
			else                quo = acc_q[T_W-1:0];
		end else begin
			if (mag > (NUM_W+1)'(33'h0_8000_0000)) quo = {1'b1, {(T_W-1){1'b0}}};
			else                                   quo = T_W'(~acc_q + 1'b1);
		end
	end

	assign done = done_q;

endmodule

// ----- rtl/aabb_dpath.sv -----
// ----------------------------------------------------------------------------
// aabb_dpath
// Datapath: query registers, box count, box memory, match logic, slab
// divider, result accumulation and the output register.
// ----------------------------------------------------------------------------
module aabb_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [2:0]                        operation,
	input  logic signed [aabb_pkg::COORD_W-1:0] ax,
	input  logic signed [aabb_pkg::COORD_W-1:0] ay,
	input  logic signed [aabb_pkg::COORD_W-1:0] bx,
	input  logic signed [aabb_pkg::COORD_W-1:0] by,
	input  logic                              completely_inside,
	input  aabb_pkg::cmd_t                    cmd,
	output aabb_pkg::status_t                 st,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic                              store_full
);
	import aabb_pkg::*;

	op_t                 op_q;
	logic signed [COORD_W-1:0] qax_q, qay_q, qbx_q, qby_q;
	logic                ci_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    idx_q;
	logic                hit_acc_q;
	logic                full_acc_q;
	logic                out_valid_q;
	logic                hit_q;
	logic                full_q;
	logic [BOX_W-1:0]    rdata;
	logic [BOX_W-1:0]    box_q;
	logic signed [T_W-1:0] t_q [4];

	logic signed [COORD_W-1:0] rx0, ry0, rx1, ry1;
	logic signed [COORD_W-1:0] bx0, by0, bx1, by1;
	logic                match;

	// Box memory
	aabb_ram #(
		.WIDTH(BOX_W),
		.DEPTH(MAX_VOLUMES)
	) u_ram (
		.clk  (clk),
		.we   (cmd.add_box),
		.waddr(count_q[IDX_W-1:0]),
		.wdata({ax, ay, bx, by}),
		.re   (cmd.rd_en),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign {rx0, ry0, rx1, ry1} = rdata;
	assign {bx0, by0, bx1, by1} = box_q;

	always_comb begin
		unique case (op_q)
			OP_POINT: match = rx0 <= qax_q && qax_q <= rx1 && ry0 <= qay_q && qay_q <= ry1;
			OP_BOX: begin
				if (ci_q)
					match = qax_q <= rx0 && rx1 <= qbx_q && qay_q <= ry0 && ry1 <= qby_q;
				else
					match = qax_q <= rx1 && rx0 <= qbx_q && qay_q <= ry1 && ry0 <= qby_q;
			end
			default: match = 1'b0;
		endcase
	end

	// Slab divider operands
	logic signed [COORD_W-1:0] edge_c, org_c, dir_c;
	logic signed [COORD_W:0]   sdiff;
	logic [COORD_W:0]          nmag, dmag;
	logic                      dneg;
	logic                      div_done;
	logic signed [T_W-1:0]     quo;

	always_comb begin
		unique case (cmd.div_sel)
			SL_X0:   edge_c = bx0;
			SL_X1:   edge_c = bx1;
			SL_Y0:   edge_c = by0;
			SL_Y1:   edge_c = by1;
			default: edge_c = bx0;
		endcase
		org_c = cmd.div_sel[1] ? qay_q : qax_q;
		dir_c = cmd.div_sel[1] ? qby_q : qbx_q;
		sdiff = {edge_c[COORD_W-1], edge_c} - {org_c[COORD_W-1], org_c};
		nmag  = sdiff[COORD_W] ? (COORD_W+1)'(-sdiff) : sdiff;
		dmag  = dir_c[COORD_W-1] ? (COORD_W+1)'(-{dir_c[COORD_W-1], dir_c})
		                         : {1'b0, dir_c};
		dneg  = sdiff[COORD_W] ^ dir_c[COORD_W-1];
	end

	aabb_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (nmag[COORD_W-1:0]),
		.den   (dmag[COORD_W-1:0]),
		.neg   (dneg),
		.done  (div_done),
		.quo   (quo)
	);

	// Ray test on the latched box and its four slab quotients
	localparam logic signed [TE_W-1:0] T_POS = TE_W'(64'sd1 <<< 40);
	localparam logic signed [TE_W-1:0] T_NEG = -T_POS;

	logic signed [TE_W-1:0] xa, xb, ya, yb, xlo, xhi, ylo, yhi, tm;
	logic pass_x, pass_y, org_in_box, ray_hit;

	always_comb begin
		xa = TE_W'(t_q[SL_X0]);
		xb = TE_W'(t_q[SL_X1]);
		ya = TE_W'(t_q[SL_Y0]);
		yb = TE_W'(t_q[SL_Y1]);
		org_in_box = bx0 <= qax_q && qax_q <= bx1 && by0 <= qay_q && qay_q <= by1;
		if (qbx_q == '0) begin
			pass_x = bx0 <= qax_q && qax_q <= bx1;
			xlo = T_NEG;
			xhi = T_POS;
		end else begin
			pass_x = 1'b1;
			xlo = (xa > xb) ? xb : xa;
			xhi = (xa > xb) ? xa : xb;
		end
		if (qby_q == '0) begin
			pass_y = by0 <= qay_q && qay_q <= by1;
			ylo = T_NEG;
			yhi = T_POS;
		end else begin
			pass_y = 1'b1;
			ylo = (ya > yb) ? yb : ya;
			yhi = (ya > yb) ? ya : yb;
		end
		tm = (xlo > ylo) ? xlo : ylo;
		ray_hit = pass_x && pass_y && !(xlo > yhi) && !(ylo > xhi) &&
		          (tm >= 0 || org_in_box);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			hit_acc_q   <= 1'b0;
			full_acc_q  <= 1'b0;
			out_valid_q <= 1'b0;
			op_q        <= OP_CLEAR;
		end else begin
			if (cmd.load_query) begin
				op_q       <= op_t'(operation);
				hit_acc_q  <= 1'b0;
				full_acc_q <= cmd.set_full;
			end
			if (cmd.clear_count) count_q <= '0;
			if (cmd.add_box)     count_q <= count_q + 1'b1;
			if (cmd.idx_clr)     idx_q <= '0;
			if (cmd.idx_inc)     idx_q <= idx_q + 1'b1;
			if (cmd.eval_box && match)  hit_acc_q <= 1'b1;
			if (cmd.ray_eval && ray_hit) hit_acc_q <= 1'b1;
			if (cmd.out_load)               out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			qax_q <= ax;
			qay_q <= ay;
			qbx_q <= bx;
			qby_q <= by;
			ci_q  <= completely_inside;
		end
		if (cmd.eval_box) box_q <= rdata;
		if (div_done)     t_q[cmd.div_sel] <= quo;
		if (cmd.out_load) begin
			hit_q  <= hit_acc_q;
			full_q <= full_acc_q;
		end
	end

	assign st.op           = op_q;
	assign st.count_zero   = count_q == '0;
	assign st.store_at_max = count_q == CNT_W'(MAX_VOLUMES);
	assign st.last         = {1'b0, idx_q} == count_q - 1'b1;
	assign st.div_done     = div_done;
	assign st.out_busy     = out_valid_q && out_stall;
	assign st.count        = count_q;

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign store_full = full_q;

endmodule

// ----- rtl/aabb_ctrl.sv -----
// ----------------------------------------------------------------------------
// aabb_ctrl
// Controller: takes one operation, walks the stored boxes and sequences the
// four slab divisions of each box for ray queries.
// ----------------------------------------------------------------------------
module aabb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        operation,
	input  aabb_pkg::status_t st,
	output aabb_pkg::cmd_t    cmd
);
	import aabb_pkg::*;

	state_t state_q, state_d;
	slab_t  sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= SL_X0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_stall    = state_q != ST_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_query = 1'b1;
					cmd.idx_clr    = 1'b1;
					state_d        = ST_DONE;
					case (operation) inside
						OP_CLEAR: cmd.clear_count = 1'b1;
						OP_ADD: begin
							if (st.store_at_max) cmd.set_full = 1'b1;
							else                 cmd.add_box  = 1'b1;
						end
						OP_POINT, OP_BOX, OP_RAY: begin
							if (!st.count_zero) state_d = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval_box = 1'b1;
				if (st.op == OP_RAY) begin
					sel_d   = SL_X0;
					state_d = ST_DIV_START;
				end else if (st.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (st.div_done) begin
					if (sel_q == SL_Y1) begin
						state_d = ST_RAY;
					end else begin
						sel_d   = slab_t'(sel_q + 1'b1);
						state_d = ST_DIV_START;
					end
				end
			end
			ST_RAY: begin
				cmd.ray_eval = 1'b1;
				if (st.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_READ;
				end
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- rtl/aabb_store_spatial_query.sv -----
// ----------------------------------------------------------------------------
// aabb_store_spatial_query
// Store of up to 64 axis-aligned boxes answering point, box and ray queries.
// ----------------------------------------------------------------------------
// Each transaction on the input is one operation and gives exactly one result
// transaction. Point and box queries read the box memory one entry at a time. A
// ray query runs four 32-step slab divisions per box through a single shared
// divider. The output register lets the next transaction be taken while a
// result is still waiting.
module aabb_store_spatial_query (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        operation,
	input  logic signed [aabb_pkg::COORD_W-1:0] ax,
	input  logic signed [aabb_pkg::COORD_W-1:0] ay,
	input  logic signed [aabb_pkg::COORD_W-1:0] bx,
	input  logic signed [aabb_pkg::COORD_W-1:0] by,
	input  logic                              completely_inside,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              hit,
	output logic                              store_full
);
	import aabb_pkg::*;

	cmd_t    cmd;
	status_t st;

	aabb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.st       (st),
		.cmd      (cmd)
	);

	aabb_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.operation        (operation),
		.ax               (ax),
		.ay               (ay),
		.bx               (bx),
		.by               (by),
		.completely_inside(completely_inside),
		.cmd              (cmd),
		.st               (st),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.hit              (hit),
		.store_full       (store_full)
	);

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		st.count <= CNT_W'(MAX_VOLUMES))
		else $error("box count beyond capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted transaction did not occupy the controller");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> !(hit && store_full))
		else $error("hit and store_full raised together");

	a_add_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.add_box |-> !st.store_at_max)
		else $error("box written into a full store");

endmodule

// ----- verif/aabb_store_spatial_query_tb.sv -----
// ----------------------------------------------------------------------------
// aabb_store_spatial_query_tb
// Self-checking bench for the box store: a queue-fed driver sends clear, add,
// point, box, ray and unused-code transactions, a local box-store predictor
// computes each result, and a monitor compares hit and store_full in order.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module aabb_store_spatial_query_tb;
	import aabb_pkg::*;

	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
	localparam longint     Q_HI           = 64'sd2147483647;
	localparam longint     Q_LO           = -64'sd2147483648;
	localparam longint     T_OPEN         = 64'sd1 << 40;
	localparam int         CYCLE_LIMIT    = 4000000;
	localparam int         TARGET_ITEMS   = 1600;

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] ax, ay, bx, by;
		logic               ci;
	} query_item_t;

	typedef struct {
		logic hit;
		logic full;
	} answer_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         operation = OP_CLEAR;
	logic signed [15:0] ax = '0, ay = '0, bx = '0, by = '0;
	logic               completely_inside = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic               store_full;

	query_item_t pending_q[$];
	answer_t     answer_q[$];
	int          n_items, n_queries, n_hits, n_drops, n_errors, cycles;
	int          in_gap, out_gap;
	bit          quiet;

	// predictor copy of the box store
	longint box_x0[MAX_VOLUMES], box_y0[MAX_VOLUMES];
	longint box_x1[MAX_VOLUMES], box_y1[MAX_VOLUMES];
	int     box_total;

	aabb_store_spatial_query u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .ax(ax), .ay(ay), .bx(bx), .by(by),
		.completely_inside(completely_inside),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .store_full(store_full)
	);

	always #10 clk = ~clk;

	function automatic longint slab_quot(longint edge_v, longint org, longint dir);
		longint q;
		q = ((edge_v - org) * 65536) / dir;
		if (q > Q_HI) q = Q_HI;
		if (q < Q_LO) q = Q_LO;
		return q;
	endfunction

	function automatic bit slab_span(longint lo, longint hi, longint org, longint dir,
			output longint tlo, output longint thi);
		longint a, b;
		if (dir == 0) begin
			tlo = -T_OPEN;
			thi = T_OPEN;
			return lo <= org && org <= hi;
		end
		a = slab_quot(lo, org, dir);
		b = slab_quot(hi, org, dir);
		tlo = (a > b) ? b : a;
		thi = (a > b) ? a : b;
		return 1'b1;
	endfunction

	function automatic bit ray_meets(int i, longint ox, longint oy, longint dx, longint dy);
		longint xa, xb, ya, yb, m;
		bit     org_in;
		if (!slab_span(box_x0[i], box_x1[i], ox, dx, xa, xb)) return 1'b0;
		if (!slab_span(box_y0[i], box_y1[i], oy, dy, ya, yb)) return 1'b0;
		if (xa > yb || ya > xb) return 1'b0;
		m = (xa > ya) ? xa : ya;
		org_in = box_x0[i] <= ox && ox <= box_x1[i] && box_y0[i] <= oy && oy <= box_y1[i];
		return m >= 0 || org_in;
	endfunction

	function automatic answer_t store_apply(query_item_t it);
		answer_t r;
		longint  qx0, qy0, qx1, qy1;
		r.hit = 1'b0;
		r.full = 1'b0;
		qx0 = it.ax; qy0 = it.ay; qx1 = it.bx; qy1 = it.by;
		case (it.op)
			OP_CLEAR: box_total = 0;
			OP_ADD: begin
				if (box_total < MAX_VOLUMES) begin
					box_x0[box_total] = qx0; box_y0[box_total] = qy0;
					box_x1[box_total] = qx1; box_y1[box_total] = qy1;
					box_total++;
				end else begin
					r.full = 1'b1;
				end
			end
			OP_POINT: begin
				for (int i = 0; i < box_total; i++)
					if (box_x0[i] <= qx0 && qx0 <= box_x1[i] &&
					    box_y0[i] <= qy0 && qy0 <= box_y1[i]) r.hit = 1'b1;
			end
			OP_BOX: begin
				for (int i = 0; i < box_total; i++)
					if (it.ci ? (qx0 <= box_x0[i] && box_x1[i] <= qx1 &&
					             qy0 <= box_y0[i] && box_y1[i] <= qy1)
					          : (qx0 <= box_x1[i] && box_x0[i] <= qx1 &&
					             qy0 <= box_y1[i] && box_y0[i] <= qy1)) r.hit = 1'b1;
			end
			OP_RAY: begin
				for (int i = 0; i < box_total; i++)
					if (ray_meets(i, qx0, qy0, qx1, qy1)) r.hit = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] pick_coord();
		if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 200)) - 16'sd100;
		return 16'($urandom);
	endfunction

	function automatic logic signed [15:0] pick_dir();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 85) return 16'($urandom_range(0, 40)) - 16'sd20;
		return 16'($urandom);
	endfunction

	task automatic push_item(logic [2:0] op, logic signed [15:0] a0, logic signed [15:0] a1,
			logic signed [15:0] b0, logic signed [15:0] b1, logic ci);
		query_item_t it;
		it.op = op; it.ax = a0; it.ay = a1; it.bx = b0; it.by = b1; it.ci = ci;
		pending_q.insert(pending_q.size(), it);
	endtask

	task automatic push_box();
		logic signed [15:0] x, y;
		x = pick_coord();
		y = pick_coord();
		if ($urandom_range(0, 9) == 0)
			push_item(OP_ADD, x, y, pick_coord(), pick_coord(), 1'($urandom_range(0, 1)));
		else
			push_item(OP_ADD, x, y, x + 16'($urandom_range(0, 40)),
				y + 16'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
	endtask

	// usually one clear, then up to 67 boxes, then a run of mostly queries against them
	task automatic push_session();
		int n_box, n_q, r;
		logic signed [15:0] x, y;
		r = $urandom_range(0, 99);
		if (r < 85) push_item(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 1'($urandom_range(0, 1)));
		n_box = ($urandom_range(0, 29) == 0) ? $urandom_range(62, 67) : $urandom_range(0, 6);
		repeat (n_box) push_box();
		n_q = $urandom_range(3, 10);
		repeat (n_q) begin
			r = $urandom_range(0, 99);
			x = pick_coord();
			y = pick_coord();
			if (r < 38)
				push_item(OP_POINT, x, y, 16'($urandom), 16'($urandom),
					1'($urandom_range(0, 1)));
			else if (r < 76)
				push_item(OP_BOX, x, y, x + 16'($urandom_range(0, 60)) - 16'sd5,
					y + 16'($urandom_range(0, 60)) - 16'sd5, 1'($urandom_range(0, 1)));
			else if (r < 91 && (n_box <= 8 || $urandom_range(0, 19) == 0))
				push_item(OP_RAY, x, y, pick_dir(), pick_dir(), 1'($urandom_range(0, 1)));
			else if (r < 96)
				push_box();
			else
				push_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), x, y,
					16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
		end
	endtask

	// driver: predict on acceptance, then present the next transaction
	always @(posedge clk or negedge arst_n) begin
		query_item_t it;
		bit          nxt_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				it.op = operation; it.ax = ax; it.ay = ay; it.bx = bx; it.by = by;
				it.ci = completely_inside;
				answer_q.insert(answer_q.size(), store_apply(it));
				n_items++;
				if (operation inside {OP_POINT, OP_BOX, OP_RAY}) n_queries++;
			end
			nxt_valid = in_valid && in_stall;
			if (!nxt_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (!quiet && $urandom_range(0, 5) == 0) begin
					in_gap = $urandom_range(0, 7);
				end else if (pending_q.size() > 0) begin
					it = pending_q.pop_front();
					operation <= it.op;
					ax <= it.ax; ay <= it.ay; bx <= it.bx; by <= it.by;
					completely_inside <= it.ci;
					nxt_valid = 1'b1;
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// monitor: check each result transaction, stall the output in bursts
	always @(posedge clk or negedge arst_n) begin
		answer_t exp_a;
		bit      nxt_stall;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (answer_q.size() == 0) begin
					$error("result with nothing expected: hit=%0b store_full=%0b",
						hit, store_full);
					n_errors++;
				end else begin
					exp_a = answer_q.pop_front();
					if (hit !== exp_a.hit) begin
						$error("hit: expected %0b, got %0b", exp_a.hit, hit);
						n_errors++;
					end
					if (store_full !== exp_a.full) begin
						$error("store_full: expected %0b, got %0b", exp_a.full, store_full);
						n_errors++;
					end
					n_hits += hit;
					n_drops += store_full;
				end
			end
			nxt_stall = 1'b0;
			if (out_gap > 0) begin
				out_gap--;
				nxt_stall = 1'b1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_gap = $urandom_range(0, 7);
				nxt_stall = 1'b1;
			end
			out_stall <= nxt_stall;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		box_total = 0;
		// directed: empty store, extremes, inverted box, each query kind, unused codes
		push_item(OP_CLEAR, 0, 0, 0, 0, 0);
		push_item(OP_POINT, 0, 0, 0, 0, 0);
		push_item(OP_ADD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1);
		push_item(OP_POINT, 16'sd32767, -16'sd32768, 0, 0, 1);
		push_item(OP_ADD, 10, 10, -10, -10, 0);
		push_item(OP_BOX, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1);
		push_item(OP_CLEAR, -1, -1, -1, -1, 1);
		push_item(OP_ADD, 0, 0, 10, 10, 0);
		push_item(OP_ADD, 10, 10, -10, -10, 0);
		push_item(OP_POINT, 10, 10, 0, 0, 0);
		push_item(OP_POINT, 11, 0, 0, 0, 0);
		push_item(OP_BOX, 10, 10, 20, 20, 0);
		push_item(OP_BOX, -1, -1, 10, 10, 1);
		push_item(OP_BOX, 1, 0, 10, 10, 1);
		push_item(OP_RAY, -5, 5, 1, 0, 0);
		push_item(OP_RAY, 5, -20, 0, 1, 0);
		push_item(OP_RAY, 20, -20, 0, 1, 0);
		push_item(OP_RAY, 5, 5, 0, 0, 0);
		push_item(OP_RAY, -5, 5, -1, 0, 0);
		push_item(OP_RAY, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 1);
		push_item(OP_RAY, -16'sd32768, 16'sd32767, 1, -1, 0);
		push_item(OP_SPARE_FIRST, 1, 1, 1, 1, 1);
		push_item(3'd6, 0, 0, 0, 0, 0);
		push_item(OP_SPARE_LAST, -1, -1, -1, -1, 1);
		while (pending_q.size() < TARGET_ITEMS) push_session();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_q.size() < 150);
		quiet = 1'b1;
		wait (pending_q.size() == 0 && !in_valid && answer_q.size() == 0);
		repeat (20) @(posedge clk);
		$display("%0d transactions (%0d queries): %0d hits, %0d adds dropped on a full store",
			n_items, n_queries, n_hits, n_drops);
		if (n_errors == 0 && answer_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d results missing", n_errors, answer_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/aabb_pkg.sv
rtl/aabb_ram.sv
rtl/aabb_div.sv
rtl/aabb_dpath.sv
rtl/aabb_ctrl.sv
rtl/aabb_store_spatial_query.sv
verif/aabb_store_spatial_query_tb.sv
